FILE: design/jsu_pkg.sv
// Shared types and constants of the JSON string unescape unit.
package jsu_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE       = 4'd0,
    MODE_STR        = 4'd1,
    MODE_ESC        = 4'd2,
    MODE_HEX        = 4'd3,
    MODE_AFTER_HIGH = 4'd4,
    MODE_HIGH_ESC   = 4'd5,
    MODE_LOW_HEX    = 4'd6,
    MODE_COPY       = 4'd7
  } mode_t;

  localparam logic [1:0] STATUS_DATA = 2'd0;
  localparam logic [1:0] STATUS_DONE = 2'd1;
  localparam logic [1:0] STATUS_ERR  = 2'd2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;
  localparam logic [15:0] HIGH_SURR_LO   = 16'hD800;
  localparam logic [15:0] HIGH_SURR_HI   = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_LO    = 16'hDC00;
  localparam logic [15:0] LOW_SURR_HI    = 16'hDFFF;

  // One piece of output: a code point to encode, or a raw byte in cp[7:0].
  typedef struct packed {
    logic        en;
    logic        raw;
    logic [20:0] cp;
  } slot_t;

  // Work for one input byte: up to two pieces, then an optional end event.
  typedef struct packed {
    slot_t      a;
    slot_t      b;
    logic [1:0] evt;
  } job_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } enc_t;

endpackage

FILE: design/jsu_front.sv
// Front end: string parser state machine that turns accepted text bytes into jobs.
module jsu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_accept,
  input  logic [7:0]       in_text_byte,
  input  logic [1:0]       in_bytes_after,
  output logic             job_push,
  output jsu_pkg::job_t    job
);

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [15:0]    hex_value_r, hex_value_nxt;
  logic [1:0]     hex_count_r, hex_count_nxt;
  logic [9:0]     high_half_r, high_half_nxt;
  logic [1:0]     copy_left_r, copy_left_nxt;

  jsu_pkg::mode_t sb_mode;
  logic [1:0]     sb_copy;
  logic [1:0]     sb_evt;
  jsu_pkg::slot_t sb_slot;

  jsu_pkg::mode_t esc_mode;
  logic           esc_hex_start;
  logic [1:0]     esc_evt;
  jsu_pkg::slot_t esc_slot;

  logic           dig_ok;
  logic [3:0]     dig_val;
  logic [15:0]    hex_acc;
  logic [1:0]     need;

  jsu_pkg::mode_t st_mode;
  logic [1:0]     st_copy;
  logic [15:0]    st_hex;
  logic [1:0]     st_cnt;
  logic [9:0]     st_high;
  logic [1:0]     evt;
  logic           skip;
  jsu_pkg::slot_t sl_a, sl_b;

  // Hex digit decode
  always_comb begin
    dig_ok  = 1'b1;
    dig_val = 4'd0;
    if (in_text_byte >= 8'h30 && in_text_byte <= 8'h39) begin
      dig_val = in_text_byte[3:0];
    end else if ((in_text_byte >= 8'h61 && in_text_byte <= 8'h66) ||
                 (in_text_byte >= 8'h41 && in_text_byte <= 8'h46)) begin
      dig_val = in_text_byte[3:0] + 4'd9;
    end else begin
      dig_ok = 1'b0;
    end
  end

  assign hex_acc = {hex_value_r[11:0], dig_val};

  // Plain string byte: close, escape, raw copy or replacement
  always_comb begin
    sb_mode = jsu_pkg::MODE_STR;
    sb_copy = 2'd0;
    sb_evt  = jsu_pkg::STATUS_DATA;
    sb_slot = '0;
    if (!in_text_byte[7]) begin
      need = 2'd0;
    end else if (in_text_byte[7:5] == 3'b110) begin
      need = 2'd1;
    end else if (in_text_byte[7:4] == 4'b1110) begin
      need = 2'd2;
    end else begin
      need = 2'd3;
    end
    if (in_text_byte == jsu_pkg::CH_QUOTE) begin
      sb_evt = jsu_pkg::STATUS_DONE;
    end else if (in_text_byte == jsu_pkg::CH_BSLASH) begin
      sb_mode = jsu_pkg::MODE_ESC;
    end else if (need == 2'd0) begin
      sb_slot = '{en: 1'b1, raw: 1'b1, cp: {13'd0, in_text_byte}};
    end else if (need > in_bytes_after) begin
      sb_slot = '{en: 1'b1, raw: 1'b0, cp: jsu_pkg::CP_REPLACEMENT};
    end else begin
      sb_slot = '{en: 1'b1, raw: 1'b1, cp: {13'd0, in_text_byte}};
      sb_copy = need;
      sb_mode = jsu_pkg::MODE_COPY;
    end
  end

  // Escape letter after a backslash
  always_comb begin
    logic [7:0] ch;
    logic       hit;
    ch            = 8'd0;
    hit           = 1'b1;
    esc_mode      = jsu_pkg::MODE_STR;
    esc_hex_start = 1'b0;
    esc_evt       = jsu_pkg::STATUS_DATA;
    unique case (in_text_byte)
      jsu_pkg::CH_QUOTE:  ch = jsu_pkg::CH_QUOTE;
      jsu_pkg::CH_BSLASH: ch = jsu_pkg::CH_BSLASH;
      jsu_pkg::CH_SLASH:  ch = jsu_pkg::CH_SLASH;
      jsu_pkg::CH_B:      ch = 8'h08;
      jsu_pkg::CH_F:      ch = 8'h0C;
      jsu_pkg::CH_N:      ch = 8'h0A;
      jsu_pkg::CH_R:      ch = 8'h0D;
      jsu_pkg::CH_T:      ch = 8'h09;
      jsu_pkg::CH_U: begin
        hit           = 1'b0;
        esc_mode      = jsu_pkg::MODE_HEX;
        esc_hex_start = 1'b1;
      end
      default: begin
        hit     = 1'b0;
        esc_evt = jsu_pkg::STATUS_ERR;
      end
    endcase
    esc_slot = '{en: hit, raw: 1'b1, cp: {13'd0, ch}};
  end

  // Next state and job contents
  always_comb begin
    st_mode = mode_r;
    st_copy = copy_left_r;
    st_hex  = hex_value_r;
    st_cnt  = hex_count_r;
    st_high = high_half_r;
    evt     = jsu_pkg::STATUS_DATA;
    skip    = 1'b0;
    sl_a    = '0;
    sl_b    = '0;
    unique case (mode_r) inside
      jsu_pkg::MODE_STR: begin
        st_mode = sb_mode;
        st_copy = sb_copy;
        evt     = sb_evt;
        sl_a    = sb_slot;
      end
      jsu_pkg::MODE_ESC: begin
        st_mode = esc_mode;
        evt     = esc_evt;
        sl_a    = esc_slot;
        if (esc_hex_start) begin
          st_hex = 16'd0;
          st_cnt = 2'd0;
        end
      end
      jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOW_HEX: begin
        if (!dig_ok) begin
          evt = jsu_pkg::STATUS_ERR;
        end else begin
          st_hex = hex_acc;
          st_cnt = hex_count_r + 2'd1;
          if (hex_count_r == 2'd3) begin
            st_mode = jsu_pkg::MODE_STR;
            if (mode_r == jsu_pkg::MODE_HEX) begin
              if (hex_acc >= jsu_pkg::HIGH_SURR_LO && hex_acc <= jsu_pkg::HIGH_SURR_HI) begin
                // Hold the high half until the next escape
                st_high = hex_acc[9:0];
                st_mode = jsu_pkg::MODE_AFTER_HIGH;
              end else if (hex_acc >= jsu_pkg::LOW_SURR_LO &&
                           hex_acc <= jsu_pkg::LOW_SURR_HI) begin
                sl_a = '{en: 1'b1, raw: 1'b0, cp: jsu_pkg::CP_REPLACEMENT};
              end else begin
                sl_a = '{en: 1'b1, raw: 1'b0, cp: {5'd0, hex_acc}};
              end
            end else if (hex_acc >= jsu_pkg::LOW_SURR_LO &&
                         hex_acc <= jsu_pkg::LOW_SURR_HI) begin
              sl_a = '{en: 1'b1, raw: 1'b0,
                       cp: jsu_pkg::CP_SUPP_BASE + {1'b0, high_half_r, hex_acc[9:0]}};
            end else begin
              sl_a = '{en: 1'b1, raw: 1'b0, cp: jsu_pkg::CP_REPLACEMENT};
              sl_b = '{en: 1'b1, raw: 1'b0, cp: {5'd0, hex_acc}};
            end
          end
        end
      end
      jsu_pkg::MODE_AFTER_HIGH: begin
        if (in_text_byte == jsu_pkg::CH_BSLASH) begin
          st_mode = jsu_pkg::MODE_HIGH_ESC;
        end else begin
          sl_a    = '{en: 1'b1, raw: 1'b0, cp: jsu_pkg::CP_REPLACEMENT};
          sl_b    = sb_slot;
          st_mode = sb_mode;
          st_copy = sb_copy;
          evt     = sb_evt;
        end
      end
      jsu_pkg::MODE_HIGH_ESC: begin
        if (in_text_byte == jsu_pkg::CH_U) begin
          st_mode = jsu_pkg::MODE_LOW_HEX;
          st_hex  = 16'd0;
          st_cnt  = 2'd0;
        end else begin
          sl_a    = '{en: 1'b1, raw: 1'b0, cp: jsu_pkg::CP_REPLACEMENT};
          sl_b    = esc_slot;
          st_mode = esc_mode;
          evt     = esc_evt;
        end
      end
      jsu_pkg::MODE_COPY: begin
        sl_a    = '{en: 1'b1, raw: 1'b1, cp: {13'd0, in_text_byte}};
        st_copy = copy_left_r - 2'd1;
        if (copy_left_r == 2'd1) begin
          st_mode = jsu_pkg::MODE_STR;
        end
      end
      default: begin
        // Idle: wait for the opening quote, drop anything else
        st_mode = jsu_pkg::MODE_IDLE;
        if (in_text_byte == jsu_pkg::CH_QUOTE) begin
          st_mode = jsu_pkg::MODE_STR;
        end else begin
          skip = 1'b1;
        end
      end
    endcase

    if (!skip && evt == jsu_pkg::STATUS_DATA && in_bytes_after == 2'd0) begin
      evt = jsu_pkg::STATUS_ERR;
    end
    if (evt == jsu_pkg::STATUS_ERR) begin
      sl_a = '0;
      sl_b = '0;
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    copy_left_nxt = copy_left_r;
    hex_value_nxt = hex_value_r;
    hex_count_nxt = hex_count_r;
    high_half_nxt = high_half_r;
    if (in_accept) begin
      if (evt != jsu_pkg::STATUS_DATA) begin
        mode_nxt      = jsu_pkg::MODE_IDLE;
        copy_left_nxt = 2'd0;
        hex_value_nxt = 16'd0;
        hex_count_nxt = 2'd0;
        high_half_nxt = 10'd0;
      end else begin
        mode_nxt      = st_mode;
        copy_left_nxt = st_copy;
        hex_value_nxt = st_hex;
        hex_count_nxt = st_cnt;
        high_half_nxt = st_high;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= jsu_pkg::MODE_IDLE;
      copy_left_r <= 2'd0;
      hex_value_r <= 16'd0;
      hex_count_r <= 2'd0;
      high_half_r <= 10'd0;
    end else begin
      mode_r      <= mode_nxt;
      copy_left_r <= copy_left_nxt;
      hex_value_r <= hex_value_nxt;
      hex_count_r <= hex_count_nxt;
      high_half_r <= high_half_nxt;
    end
  end

  assign job      = '{a: sl_a, b: sl_b, evt: evt};
  assign job_push = in_accept && (sl_a.en || sl_b.en || evt != jsu_pkg::STATUS_DATA);

endmodule

FILE: design/jsu_queue.sv
// Job queue between the parser and the output serializer.
module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          nonempty,
  output jsu_pkg::job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  jsu_pkg::job_t  mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full     = (count_r == FULL_CNT);
  assign nonempty = (count_r != '0);
  assign head     = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: design/jsu_back.sv
// Back end: encodes a job to UTF-8 and sends its results one per transfer.
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_avail,
  input  jsu_pkg::job_t job,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic [1:0]    out_status,
  output logic          out_last_of_item
);

  function automatic jsu_pkg::enc_t encode(input jsu_pkg::slot_t s);
    jsu_pkg::enc_t e;
    e = '0;
    if (!s.en) begin
      e.len = 3'd0;
    end else if (s.raw || s.cp < 21'h80) begin
      e.len      = 3'd1;
      e.bytes[0] = s.cp[7:0];
    end else if (s.cp < 21'h800) begin
      e.len      = 3'd2;
      e.bytes[0] = {3'b110, s.cp[10:6]};
      e.bytes[1] = {2'b10, s.cp[5:0]};
    end else if (s.cp < 21'h10000) begin
      e.len      = 3'd3;
      e.bytes[0] = {4'b1110, s.cp[15:12]};
      e.bytes[1] = {2'b10, s.cp[11:6]};
      e.bytes[2] = {2'b10, s.cp[5:0]};
    end else begin
      e.len      = 3'd4;
      e.bytes[0] = {5'b11110, s.cp[20:18]};
      e.bytes[1] = {2'b10, s.cp[17:12]};
      e.bytes[2] = {2'b10, s.cp[11:6]};
      e.bytes[3] = {2'b10, s.cp[5:0]};
    end
    return e;
  endfunction

  logic          busy_r, busy_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic [2:0]    ndata_r, ndata_nxt;
  logic [2:0]    total_r, total_nxt;
  logic [1:0]    evt_r, evt_nxt;
  logic [7:0]    bytes_r [6];
  logic [7:0]    bytes_nxt [6];
  jsu_pkg::enc_t enc_a, enc_b;
  logic          xfer, last, advance;

  assign enc_a = encode(job.a);
  assign enc_b = encode(job.b);

  // Lay out the pieces back to back
  always_comb begin
    logic [2:0] j;
    for (int i = 0; i < 6; i++) begin
      j = 3'(i) - enc_a.len;
      if (3'(i) < enc_a.len) begin
        bytes_nxt[i] = enc_a.bytes[i[1:0]];
      end else begin
        bytes_nxt[i] = enc_b.bytes[j[1:0]];
      end
    end
  end

  assign out_valid = busy_r;
  assign last      = (idx_r == total_r - 3'd1);
  assign xfer      = busy_r && !out_stall;
  assign advance   = !busy_r || (xfer && last);
  assign job_pop   = advance && job_avail;

  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    ndata_nxt = ndata_r;
    total_nxt = total_r;
    evt_nxt   = evt_r;
    if (advance) begin
      busy_nxt = job_avail;
      idx_nxt  = 3'd0;
      if (job_avail) begin
        ndata_nxt = enc_a.len + enc_b.len;
        total_nxt = enc_a.len + enc_b.len + {2'd0, job.evt != jsu_pkg::STATUS_DATA};
        evt_nxt   = job.evt;
      end
    end else if (xfer) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      idx_r   <= 3'd0;
      ndata_r <= 3'd0;
      total_r <= 3'd0;
      evt_r   <= jsu_pkg::STATUS_DATA;
    end else begin
      busy_r  <= busy_nxt;
      idx_r   <= idx_nxt;
      ndata_r <= ndata_nxt;
      total_r <= total_nxt;
      evt_r   <= evt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      bytes_r <= bytes_nxt;
    end
  end

  always_comb begin
    if (idx_r < ndata_r) begin
      out_byte   = bytes_r[idx_r];
      out_status = jsu_pkg::STATUS_DATA;
    end else begin
      out_byte   = 8'd0;
      out_status = evt_r;
    end
  end

  assign out_last_of_item = last;

endmodule

FILE: design/json_string_unescape_utf8_unit.sv
// Top level of the JSON string unescape unit: parser, job queue, UTF-8 serializer.
// Feeds one quoted JSON string a byte per transfer, opening quote first, and
// returns its decoded UTF-8 bytes one per transfer, then a done or error result
// (last_of_item marks the final result of each input byte). An input byte is
// taken every cycle while the job queue has room; each byte produces zero to six
// results, and the serializer sends one result per cycle while out_stall is low,
// so bytes that expand to several results (escapes, surrogate pairs, replacement
// characters) are absorbed by the QUEUE_DEPTH-entry queue and stall the input
// only when it fills; jobs are queued, then loaded into the serializer registers.
module json_string_unescape_utf8_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic [1:0] in_bytes_after,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_status,
  output logic       out_last_of_item
);

  logic          in_accept;
  logic          job_push;
  jsu_pkg::job_t push_job;
  logic          job_pop;
  logic          q_full;
  logic          q_nonempty;
  jsu_pkg::job_t head_job;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  jsu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_accept      (in_accept),
    .in_text_byte   (in_text_byte),
    .in_bytes_after (in_bytes_after),
    .job_push       (job_push),
    .job            (push_job)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (head_job)
  );

  jsu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_avail        (q_nonempty),
    .job              (head_job),
    .job_pop          (job_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_status       (out_status),
    .out_last_of_item (out_last_of_item)
  );

endmodule

FILE: dv/jsu_decode_checker.sv
// Checker for the JSON string unescape unit: predicts decoded bytes and compares results.
`timescale 1ns / 1ps

module jsu_decode_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic [1:0] in_bytes_after,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic [1:0] out_status,
  input  logic       out_last_of_item,
  output int         fail_count,
  output int         pending,
  output int         bytes_in_string,
  output int         results_checked,
  output int         strings_closed,
  output int         strings_failed
);

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } decoded_t;

  decoded_t decoded_q[$];

  // Predicted decoder state.
  jsu_pkg::mode_t mode;
  logic [15:0]    hex_value;
  logic [1:0]     hex_count;
  logic [9:0]     high_half;
  logic [1:0]     copy_left;

  // Bytes produced by the current text byte, and how the string ends (data = still open).
  logic [7:0] utf8_buf [8];
  int         utf8_len;
  logic [1:0] end_status;

  task automatic clear_state();
    mode      = jsu_pkg::MODE_IDLE;
    hex_value = '0;
    hex_count = '0;
    high_half = '0;
    copy_left = '0;
  endtask

  task automatic put_byte(input logic [7:0] b);
    if (utf8_len < 8) begin
      utf8_buf[utf8_len] = b;
      utf8_len++;
    end
  endtask

  task automatic put_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      put_byte({3'b110, cp[10:6]});
      put_byte({2'b10, cp[5:0]});
    end else if (cp < jsu_pkg::CP_SUPP_BASE) begin
      put_byte({4'b1110, cp[15:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end else begin
      put_byte({5'b11110, cp[20:18]});
      put_byte({2'b10, cp[17:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end
  endtask

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic take_hex_digit(input logic [7:0] c, output bit full);
    int d;
    d = hex_nibble(c);
    full = 1'b0;
    if (d < 0) begin
      end_status = jsu_pkg::STATUS_ERR;
    end else begin
      hex_value = {hex_value[11:0], d[3:0]};
      if (hex_count == 2'd3) begin
        hex_count = '0;
        full = 1'b1;
      end else begin
        hex_count = hex_count + 2'd1;
      end
    end
  endtask

  task automatic take_string_byte(input logic [7:0] c, input logic [1:0] after);
    logic [1:0] tail;
    if (c == jsu_pkg::CH_QUOTE) begin
      end_status = jsu_pkg::STATUS_DONE;
    end else if (c == jsu_pkg::CH_BSLASH) begin
      mode = jsu_pkg::MODE_ESC;
    end else if (c < 8'h80) begin
      put_byte(c);
    end else begin
      // Anything that is not a two- or three-byte lead counts as a four-byte lead.
      if (c[7:5] == 3'b110) tail = 2'd1;
      else if (c[7:4] == 4'b1110) tail = 2'd2;
      else tail = 2'd3;
      if (tail > after) begin
        put_cp(jsu_pkg::CP_REPLACEMENT);
      end else begin
        put_byte(c);
        copy_left = tail;
        mode = jsu_pkg::MODE_COPY;
      end
    end
  endtask

  task automatic take_escape(input logic [7:0] e);
    mode = jsu_pkg::MODE_STR;
    case (e) inside
      jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: put_byte(e);
      jsu_pkg::CH_B: put_byte(8'h08);
      jsu_pkg::CH_F: put_byte(8'h0C);
      jsu_pkg::CH_N: put_byte(8'h0A);
      jsu_pkg::CH_R: put_byte(8'h0D);
      jsu_pkg::CH_T: put_byte(8'h09);
      jsu_pkg::CH_U: begin
        mode = jsu_pkg::MODE_HEX;
        hex_value = '0;
        hex_count = '0;
      end
      default: end_status = jsu_pkg::STATUS_ERR;
    endcase
  endtask

  task automatic decode_text_byte(input logic [7:0] c, input logic [1:0] after);
    bit       full;
    int       n_data;
    int       total;
    int       i;
    decoded_t r;
    utf8_len = 0;
    end_status = jsu_pkg::STATUS_DATA;
    // Drop anything but a quote while idle.
    if (mode == jsu_pkg::MODE_IDLE && c != jsu_pkg::CH_QUOTE) return;
    bytes_in_string++;
    case (mode)
      jsu_pkg::MODE_IDLE: mode = jsu_pkg::MODE_STR;
      jsu_pkg::MODE_STR: take_string_byte(c, after);
      jsu_pkg::MODE_ESC: take_escape(c);
      jsu_pkg::MODE_HEX: begin
        take_hex_digit(c, full);
        if (full) begin
          mode = jsu_pkg::MODE_STR;
          if (hex_value >= jsu_pkg::HIGH_SURR_LO &&
              hex_value <= jsu_pkg::HIGH_SURR_HI) begin
            high_half = hex_value[9:0];
            mode = jsu_pkg::MODE_AFTER_HIGH;
          end else if (hex_value >= jsu_pkg::LOW_SURR_LO &&
                       hex_value <= jsu_pkg::LOW_SURR_HI) begin
            put_cp(jsu_pkg::CP_REPLACEMENT);
          end else begin
            put_cp({5'd0, hex_value});
          end
        end
      end
      jsu_pkg::MODE_AFTER_HIGH: begin
        if (c == jsu_pkg::CH_BSLASH) begin
          mode = jsu_pkg::MODE_HIGH_ESC;
        end else begin
          put_cp(jsu_pkg::CP_REPLACEMENT);
          mode = jsu_pkg::MODE_STR;
          take_string_byte(c, after);
        end
      end
      jsu_pkg::MODE_HIGH_ESC: begin
        if (c == jsu_pkg::CH_U) begin
          mode = jsu_pkg::MODE_LOW_HEX;
          hex_value = '0;
          hex_count = '0;
        end else begin
          put_cp(jsu_pkg::CP_REPLACEMENT);
          take_escape(c);
        end
      end
      jsu_pkg::MODE_LOW_HEX: begin
        take_hex_digit(c, full);
        if (full) begin
          mode = jsu_pkg::MODE_STR;
          if (hex_value >= jsu_pkg::LOW_SURR_LO && hex_value <= jsu_pkg::LOW_SURR_HI) begin
            put_cp(jsu_pkg::CP_SUPP_BASE + {1'b0, high_half, hex_value[9:0]});
          end else begin
            put_cp(jsu_pkg::CP_REPLACEMENT);
            put_cp({5'd0, hex_value});
          end
        end
      end
      jsu_pkg::MODE_COPY: begin
        put_byte(c);
        copy_left = copy_left - 2'd1;
        if (copy_left == 2'd0) mode = jsu_pkg::MODE_STR;
      end
      default: mode = jsu_pkg::MODE_STR;
    endcase

    if (end_status == jsu_pkg::STATUS_DATA && after == 2'd0) end_status = jsu_pkg::STATUS_ERR;
    if (end_status != jsu_pkg::STATUS_DATA) clear_state();
    if (end_status == jsu_pkg::STATUS_ERR) utf8_len = 0;

    n_data = (utf8_len < 6) ? utf8_len : 6;
    total = n_data + ((end_status != jsu_pkg::STATUS_DATA && n_data < 6) ? 1 : 0);
    for (i = 0; i < n_data; i++) begin
      r.data = utf8_buf[i];
      r.status = jsu_pkg::STATUS_DATA;
      r.last = (i == total - 1);
      decoded_q.push_back(r);
    end
    if (total > n_data) begin
      r.data = 8'h00;
      r.status = end_status;
      r.last = 1'b1;
      decoded_q.push_back(r);
    end
  endtask

  task automatic check_result();
    decoded_t exp_r;
    results_checked++;
    if (out_status == jsu_pkg::STATUS_DONE) strings_closed++;
    if (out_status == jsu_pkg::STATUS_ERR) strings_failed++;
    if (decoded_q.size() == 0) begin
      $error("unexpected result: out_byte %h out_status %0d out_last_of_item %0b",
             out_byte, out_status, out_last_of_item);
      fail_count++;
    end else begin
      exp_r = decoded_q.pop_front();
      if (out_byte !== exp_r.data) begin
        $error("out_byte: expected %h, actual %h", exp_r.data, out_byte);
        fail_count++;
      end
      if (out_status !== exp_r.status) begin
        $error("out_status: expected %0d, actual %0d", exp_r.status, out_status);
        fail_count++;
      end
      if (out_last_of_item !== exp_r.last) begin
        $error("out_last_of_item: expected %0b, actual %0b", exp_r.last, out_last_of_item);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      decoded_q.delete();
      fail_count = 0;
      bytes_in_string = 0;
      results_checked = 0;
      strings_closed = 0;
      strings_failed = 0;
    end else begin
      if (in_valid && !in_stall) decode_text_byte(in_text_byte, in_bytes_after);
      if (out_valid && !out_stall) check_result();
    end
    pending = decoded_q.size();
  end

endmodule

FILE: dv/testbench.sv
// Top of the JSON string unescape testbench: clock, reset, text stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int ITEM_TARGET  = 360;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte = 8'h00;
  logic [1:0] in_bytes_after = 2'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_status;
  logic       out_last_of_item;

  int fail_count;
  int pending;
  int bytes_in_string;
  int results_checked;
  int strings_closed;
  int strings_failed;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  logic [7:0] text_q[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  json_string_unescape_utf8_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_bytes_after   (in_bytes_after),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_status       (out_status),
    .out_last_of_item (out_last_of_item)
  );

  jsu_decode_checker i_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_bytes_after   (in_bytes_after),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_status       (out_status),
    .out_last_of_item (out_last_of_item),
    .fail_count       (fail_count),
    .pending          (pending),
    .bytes_in_string  (bytes_in_string),
    .results_checked  (results_checked),
    .strings_closed   (strings_closed),
    .strings_failed   (strings_failed)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    return ($urandom_range(1) ? "a" : "A") + n - 8'd10;
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_escape_char(input logic [7:0] c);
    case (c) inside
      jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
      jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T,
      jsu_pkg::CH_U: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] pick_simple_escape();
    case ($urandom_range(7))
      0: return jsu_pkg::CH_QUOTE;
      1: return jsu_pkg::CH_BSLASH;
      2: return jsu_pkg::CH_SLASH;
      3: return jsu_pkg::CH_B;
      4: return jsu_pkg::CH_F;
      5: return jsu_pkg::CH_N;
      6: return jsu_pkg::CH_R;
      default: return jsu_pkg::CH_T;
    endcase
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    b = 8'($urandom_range(127));
    if (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH) b = "a";
    return b;
  endfunction

  task automatic add_str(input string s);
    for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
  endtask

  task automatic add_escape_u(input logic [15:0] v);
    text_q.push_back(jsu_pkg::CH_BSLASH);
    text_q.push_back(jsu_pkg::CH_U);
    for (int k = 3; k >= 0; k--) text_q.push_back(hex_char(v[k*4 +: 4]));
  endtask

  // Hold the payload until the transfer, idling at random beforehand.
  task automatic send_item(input logic [7:0] b, input logic [1:0] after);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_bytes_after <= after;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_text(input bit jitter);
    int         left;
    logic [1:0] after;
    for (int k = 0; k < text_q.size(); k++) begin
      left = text_q.size() - 1 - k;
      after = (left > 3) ? 2'd3 : left[1:0];
      // Occasionally claim a different remaining count than the text really has.
      if (jitter && $urandom_range(19) == 0) after = 2'($urandom_range(3));
      send_item(text_q[k], after);
    end
    text_q.delete();
  endtask

  task automatic add_token();
    logic [7:0] lead;
    int         tail;
    case ($urandom_range(11)) inside
      0, 1: text_q.push_back(plain_char());
      2: begin
        text_q.push_back(jsu_pkg::CH_BSLASH);
        text_q.push_back(pick_simple_escape());
      end
      3: add_escape_u(16'($urandom_range(16'h007F)));
      4: add_escape_u(16'($urandom_range(16'h0080, 16'h07FF)));
      5: add_escape_u(16'($urandom_range(16'hFFFF)));
      6, 7: begin
        add_escape_u(16'($urandom_range(jsu_pkg::HIGH_SURR_LO, jsu_pkg::HIGH_SURR_HI)));
        add_escape_u(16'($urandom_range(jsu_pkg::LOW_SURR_LO, jsu_pkg::LOW_SURR_HI)));
      end
      8: add_escape_u(16'($urandom_range(jsu_pkg::LOW_SURR_LO, jsu_pkg::LOW_SURR_HI)));
      9: begin
        // High surrogate followed by something other than a low one.
        add_escape_u(16'($urandom_range(jsu_pkg::HIGH_SURR_LO, jsu_pkg::HIGH_SURR_HI)));
        case ($urandom_range(2))
          0: text_q.push_back(plain_char());
          1: begin
            text_q.push_back(jsu_pkg::CH_BSLASH);
            text_q.push_back(pick_simple_escape());
          end
          default: add_escape_u(16'($urandom_range(1) ? $urandom_range(16'h0000, 16'hDBFF)
                                                      : $urandom_range(16'hE000, 16'hFFFF)));
        endcase
      end
      10: begin
        tail = int'($urandom_range(1, 3));
        case (tail)
          1: lead = 8'hC0 | 8'($urandom_range(31));
          2: lead = 8'hE0 | 8'($urandom_range(15));
          default: lead = $urandom_range(1) ? (8'hF0 | 8'($urandom_range(15)))
                                            : 8'($urandom_range(8'h80, 8'hBF));
        endcase
        text_q.push_back(lead);
        repeat (tail) text_q.push_back(8'($urandom_range(255)));
      end
      default: text_q.push_back(8'($urandom_range(255)));
    endcase
  endtask

  task automatic build_random_text();
    int         r;
    logic [7:0] b;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(255)));
    end
    text_q.push_back(jsu_pkg::CH_QUOTE);
    repeat ($urandom_range(6)) add_token();
    r = int'($urandom_range(99));
    if (r < 75) begin
      text_q.push_back(jsu_pkg::CH_QUOTE);
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(255)));
      end
    end else if (r < 87) begin
      // cut off inside the string
    end else if (r < 94) begin
      text_q.push_back(jsu_pkg::CH_BSLASH);
      do b = 8'($urandom_range(255)); while (is_escape_char(b));
      text_q.push_back(b);
    end else begin
      text_q.push_back(jsu_pkg::CH_BSLASH);
      text_q.push_back(jsu_pkg::CH_U);
      repeat ($urandom_range(3)) text_q.push_back(hex_char(4'($urandom_range(15))));
      do b = 8'($urandom_range(255)); while (is_hex(b));
      text_q.push_back(b);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_stall_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_stall_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (phase == 0) begin
        // Idle junk, zero escape, lone low half, high half then a simple escape.
        add_str("a\"\\u0000\\uDFFF\\uDBFF\\n\"");
        send_text(1'b0);
        // Four-byte lead and stray continuation too close to the end.
        text_q.push_back(jsu_pkg::CH_QUOTE);
        text_q.push_back(8'hFF);
        text_q.push_back(8'h80);
        text_q.push_back(8'hBF);
        send_text(1'b0);
        // Opening quote as the last byte of the text.
        text_q.push_back(jsu_pkg::CH_QUOTE);
        send_text(1'b0);
        add_str("\"\\q");
        send_text(1'b0);
      end
      while (bytes_in_string < ITEM_TARGET * (phase + 1) / 3) begin
        build_random_text();
        send_text(1'b1);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Fed %0d string bytes under three idle/stall mixes; checked %0d results",
             bytes_in_string, results_checked);
    $display("(%0d strings closed, %0d ended in error).", strings_closed, strings_failed);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
